>>> hw/rtl/ctc_pkg.sv
`timescale 1ns / 1ps

package ctc_pkg;

    // Operations of the shared arithmetic and sine units
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_SIN
    } op_t;

    // Operand and destination slots of the sequencer
    typedef enum logic [5:0] {
        SL_ZERO,
        SL_SPDEG,
        SL_THDEG,
        SL_D2R,
        SL_TSTEP,
        SL_LPTC,
        SL_TLP,
        SL_MASS,
        SL_LEN,
        SL_DAMP,
        SL_GRAV,
        SL_KP,
        SL_KI,
        SL_KD,
        SL_TC,
        SL_SP,
        SL_TH,
        SL_SFILT,
        SL_DEN,
        SL_SPRIN,
        SL_SPROUT,
        SL_SPAIN,
        SL_SPAOUT,
        SL_ERR,
        SL_PERR,
        SL_PERATE,
        SL_INTEG,
        SL_ARIN,
        SL_AROUT,
        SL_T0,
        SL_T1,
        SL_T2
    } slot_t;

    typedef struct packed {
        op_t   op;
        slot_t src_a;
        slot_t src_b;
        slot_t dst;
    } uop_t;

    // Configuration port
    localparam int CFG_DATA_W  = 26;
    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_MASS    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KP      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_KI      = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_KD      = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_TC = 4'd7;

    // Micro-program
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEP_TORQUE = 6'd35;
    localparam logic [STEP_W-1:0] STEP_LAST   = 6'd45;

    // CORDIC sine: angles in degrees with 24 fraction bits, x and y with 30
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_IW    = 5;
    localparam int CORDIC_XW    = 34;
    localparam int CORDIC_ZW    = 35;
    localparam int CORDIC_Q     = 24;
    localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [CORDIC_ZW-1:0] ATAN_DEG_Q24 [CORDIC_STEPS] = '{
        35'sd754974720, 35'sd445687602, 35'sd235489088, 35'sd119537938,
        35'sd60000934,  35'sd30029717,  35'sd15018523,  35'sd7509720,
        35'sd3754917,   35'sd1877466,   35'sd938734,    35'sd469367,
        35'sd234684,    35'sd117342,    35'sd58671,     35'sd29335,
        35'sd14668,     35'sd7334,      35'sd3667,      35'sd1833
    };

    function automatic uop_t mk(input op_t op, input slot_t a, input slot_t b,
                                input slot_t d);
        uop_t u;
        u.op    = op;
        u.src_a = a;
        u.src_b = b;
        u.dst   = d;
        return u;
    endfunction

    // One control tick as a sequence of shared-unit operations
    function automatic uop_t prog(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            // convert angles to radians
            6'd0:  u = mk(OP_MUL, SL_SPDEG,  SL_D2R,    SL_SP);
            6'd1:  u = mk(OP_MUL, SL_THDEG,  SL_D2R,    SL_TH);
            // setpoint low-pass filter
            6'd2:  u = mk(OP_MUL, SL_TSTEP,  SL_SP,     SL_T0);
            6'd3:  u = mk(OP_MUL, SL_LPTC,   SL_SFILT,  SL_T1);
            6'd4:  u = mk(OP_ADD, SL_T0,     SL_T1,     SL_T0);
            6'd5:  u = mk(OP_DIV, SL_T0,     SL_TLP,    SL_SFILT);
            6'd6:  u = mk(OP_ADD, SL_TSTEP,  SL_TC,     SL_DEN);
            // setpoint rate
            6'd7:  u = mk(OP_SUB, SL_SFILT,  SL_SPRIN,  SL_T0);
            6'd8:  u = mk(OP_MUL, SL_TC,     SL_SPROUT, SL_T1);
            6'd9:  u = mk(OP_ADD, SL_T0,     SL_T1,     SL_T0);
            6'd10: u = mk(OP_DIV, SL_T0,     SL_DEN,    SL_SPROUT);
            6'd11: u = mk(OP_ADD, SL_SFILT,  SL_ZERO,   SL_SPRIN);
            // setpoint acceleration
            6'd12: u = mk(OP_SUB, SL_SPROUT, SL_SPAIN,  SL_T0);
            6'd13: u = mk(OP_MUL, SL_TC,     SL_SPAOUT, SL_T1);
            6'd14: u = mk(OP_ADD, SL_T0,     SL_T1,     SL_T0);
            6'd15: u = mk(OP_DIV, SL_T0,     SL_DEN,    SL_SPAOUT);
            6'd16: u = mk(OP_ADD, SL_SPROUT, SL_ZERO,   SL_SPAIN);
            // PID
            6'd17: u = mk(OP_SUB, SL_SFILT,  SL_TH,     SL_ERR);
            6'd18: u = mk(OP_MUL, SL_KI,     SL_ERR,    SL_T0);
            6'd19: u = mk(OP_MUL, SL_T0,     SL_TSTEP,  SL_T0);
            6'd20: u = mk(OP_ADD, SL_INTEG,  SL_T0,     SL_INTEG);
            6'd21: u = mk(OP_SUB, SL_ERR,    SL_PERR,   SL_T0);
            6'd22: u = mk(OP_MUL, SL_TC,     SL_PERATE, SL_T1);
            6'd23: u = mk(OP_ADD, SL_T0,     SL_T1,     SL_T0);
            6'd24: u = mk(OP_DIV, SL_T0,     SL_DEN,    SL_PERATE);
            6'd25: u = mk(OP_ADD, SL_ERR,    SL_ZERO,   SL_PERR);
            6'd26: u = mk(OP_MUL, SL_KP,     SL_ERR,    SL_T0);
            6'd27: u = mk(OP_ADD, SL_T0,     SL_INTEG,  SL_T0);
            6'd28: u = mk(OP_MUL, SL_KD,     SL_PERATE, SL_T1);
            6'd29: u = mk(OP_ADD, SL_T0,     SL_T1,     SL_T2);
            // measured angle rate
            6'd30: u = mk(OP_SUB, SL_TH,     SL_ARIN,   SL_T0);
            6'd31: u = mk(OP_MUL, SL_TC,     SL_AROUT,  SL_T1);
            6'd32: u = mk(OP_ADD, SL_T0,     SL_T1,     SL_T0);
            6'd33: u = mk(OP_DIV, SL_T0,     SL_DEN,    SL_AROUT);
            6'd34: u = mk(OP_ADD, SL_TH,     SL_ZERO,   SL_ARIN);
            // torque
            6'd35: u = mk(OP_MUL, SL_MASS,   SL_LEN,    SL_T0);
            6'd36: u = mk(OP_MUL, SL_T0,     SL_LEN,    SL_T0);
            6'd37: u = mk(OP_SIN, SL_THDEG,  SL_ZERO,   SL_T1);
            6'd38: u = mk(OP_MUL, SL_T1,     SL_MASS,   SL_T1);
            6'd39: u = mk(OP_MUL, SL_T1,     SL_LEN,    SL_T1);
            6'd40: u = mk(OP_MUL, SL_T1,     SL_GRAV,   SL_T1);
            6'd41: u = mk(OP_ADD, SL_SPAOUT, SL_T2,     SL_T2);
            6'd42: u = mk(OP_MUL, SL_T2,     SL_T0,     SL_T0);
            6'd43: u = mk(OP_ADD, SL_T0,     SL_T1,     SL_T0);
            6'd44: u = mk(OP_MUL, SL_AROUT,  SL_DAMP,   SL_T1);
            6'd45: u = mk(OP_ADD, SL_T0,     SL_T1,     SL_T0);
            default: u = mk(OP_ADD, SL_ZERO, SL_ZERO,   SL_ZERO);
        endcase
        return u;
    endfunction

endpackage

>>> hw/rtl/computed_torque_controller.sv
`timescale 1ns / 1ps

// Computed-torque pendulum controller. Each input item is one control tick
// (setpoint and measured angle in degrees, signed fixed point with FRAC_BITS
// fraction bits); each tick yields one item with the saturated 32-bit torque
// and a flag that is set when any step of the torque formula or the final
// 32-bit fit clipped. A tick runs as a fixed 46-step micro-program on one
// shared bit-serial multiply/divide unit and one CORDIC sine unit. s_ready
// is high only between ticks; a finished result waits in the output register
// while the next tick is taken. Configuration registers are written through
// cfg_wr_en, cfg_index and cfg_wdata; the user must write them only while no
// tick is in flight, which the block itself does not enforce; indexes above
// 7 are ignored.

module computed_torque_controller #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [ctc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ctc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [31:0]                    s_setpoint_deg,
    input  logic signed [31:0]                    s_measured_deg,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [31:0]                    m_torque_cmd,
    output logic                                  m_saturated
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int DW = ctc_pkg::CFG_DATA_W;
    localparam int SW = ctc_pkg::STEP_W;
    localparam int IW = (W > 32) ? W : 33;
    localparam int EW = W + DW;
    localparam logic signed [W-1:0] WMAX_S = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN_S = {1'b1, {(W-1){1'b0}}};
    localparam longint unsigned TSTEP_U = ((64'd1 << F) + 64'd50) / 64'd100;
    localparam logic signed [W-1:0] TSTEP = W'(TSTEP_U);
    localparam logic signed [W-1:0] LPTC  = W'(64'd3 << F);
    localparam logic signed [W-1:0] TLP   = W'(TSTEP_U + (64'd3 << F));
    localparam logic signed [W-1:0] D2R   =
        W'((64'd74961321 + (64'd1 << (31 - F))) >> (32 - F));

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    logic [SW-1:0] step_reg;
    logic hit_reg;

    // configuration registers
    logic [22:0] mass_reg, length_reg, damping_reg, gravity_reg, tc_reg;
    logic [25:0] kp_reg, ki_reg, kd_reg;

    // latched inputs, controller state and scratch
    logic signed [W-1:0] spdeg_reg, thdeg_reg;
    logic signed [W-1:0] sp_reg, th_reg, sfilt_reg, den_reg;
    logic signed [W-1:0] sprin_reg, sprout_reg, spain_reg, spaout_reg;
    logic signed [W-1:0] err_reg, perr_reg, perate_reg, integ_reg;
    logic signed [W-1:0] arin_reg, arout_reg;
    logic signed [W-1:0] t0_reg, t1_reg, t2_reg;

    logic        m_valid_reg;
    logic [31:0] m_torque_reg;
    logic        m_sat_reg;

    ctc_pkg::uop_t       uop;
    logic signed [W-1:0] opa, opb;
    logic signed [W-1:0] m_w, l_w, k_w, g_w, kp_w, ki_w, kd_w, tc_w;
    logic                arith_start, sine_start;
    logic                arith_done, sine_done, unit_done;
    logic signed [W-1:0] arith_res, sine_res, unit_res;
    logic                arith_ovf, unit_ovf;
    logic signed [IW-1:0] torque_x;
    logic                clip;
    logic [31:0]         torque_32;

    // clamp an unsigned register to the word maximum
    function automatic logic signed [W-1:0] reg_word(input logic [DW-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        if (ext > EW'(WMAX_S)) begin
            return WMAX_S;
        end
        return W'(ext);
    endfunction

    // sign-extend a 32-bit input and clamp it to the word
    function automatic logic signed [W-1:0] in_word(input logic signed [31:0] v);
        logic signed [IW-1:0] ext;
        ext = IW'(v);
        if (ext > IW'(WMAX_S)) begin
            return WMAX_S;
        end
        if (ext < IW'(WMIN_S)) begin
            return WMIN_S;
        end
        return W'(ext);
    endfunction

    assign m_w  = reg_word(DW'(mass_reg));
    assign l_w  = reg_word(DW'(length_reg));
    assign k_w  = reg_word(DW'(damping_reg));
    assign g_w  = reg_word(DW'(gravity_reg));
    assign kp_w = reg_word(kp_reg);
    assign ki_w = reg_word(ki_reg);
    assign kd_w = reg_word(kd_reg);
    assign tc_w = reg_word(DW'(tc_reg));

    assign uop = ctc_pkg::prog(step_reg);

    // operand A select
    always_comb begin
        case (uop.src_a)
            ctc_pkg::SL_SPDEG:  opa = spdeg_reg;
            ctc_pkg::SL_THDEG:  opa = thdeg_reg;
            ctc_pkg::SL_D2R:    opa = D2R;
            ctc_pkg::SL_TSTEP:  opa = TSTEP;
            ctc_pkg::SL_LPTC:   opa = LPTC;
            ctc_pkg::SL_TLP:    opa = TLP;
            ctc_pkg::SL_MASS:   opa = m_w;
            ctc_pkg::SL_LEN:    opa = l_w;
            ctc_pkg::SL_DAMP:   opa = k_w;
            ctc_pkg::SL_GRAV:   opa = g_w;
            ctc_pkg::SL_KP:     opa = kp_w;
            ctc_pkg::SL_KI:     opa = ki_w;
            ctc_pkg::SL_KD:     opa = kd_w;
            ctc_pkg::SL_TC:     opa = tc_w;
            ctc_pkg::SL_SP:     opa = sp_reg;
            ctc_pkg::SL_TH:     opa = th_reg;
            ctc_pkg::SL_SFILT:  opa = sfilt_reg;
            ctc_pkg::SL_DEN:    opa = den_reg;
            ctc_pkg::SL_SPRIN:  opa = sprin_reg;
            ctc_pkg::SL_SPROUT: opa = sprout_reg;
            ctc_pkg::SL_SPAIN:  opa = spain_reg;
            ctc_pkg::SL_SPAOUT: opa = spaout_reg;
            ctc_pkg::SL_ERR:    opa = err_reg;
            ctc_pkg::SL_PERR:   opa = perr_reg;
            ctc_pkg::SL_PERATE: opa = perate_reg;
            ctc_pkg::SL_INTEG:  opa = integ_reg;
            ctc_pkg::SL_ARIN:   opa = arin_reg;
            ctc_pkg::SL_AROUT:  opa = arout_reg;
            ctc_pkg::SL_T0:     opa = t0_reg;
            ctc_pkg::SL_T1:     opa = t1_reg;
            ctc_pkg::SL_T2:     opa = t2_reg;
            default:            opa = '0;
        endcase
    end

    // operand B select
    always_comb begin
        case (uop.src_b)
            ctc_pkg::SL_SPDEG:  opb = spdeg_reg;
            ctc_pkg::SL_THDEG:  opb = thdeg_reg;
            ctc_pkg::SL_D2R:    opb = D2R;
            ctc_pkg::SL_TSTEP:  opb = TSTEP;
            ctc_pkg::SL_LPTC:   opb = LPTC;
            ctc_pkg::SL_TLP:    opb = TLP;
            ctc_pkg::SL_MASS:   opb = m_w;
            ctc_pkg::SL_LEN:    opb = l_w;
            ctc_pkg::SL_DAMP:   opb = k_w;
            ctc_pkg::SL_GRAV:   opb = g_w;
            ctc_pkg::SL_KP:     opb = kp_w;
            ctc_pkg::SL_KI:     opb = ki_w;
            ctc_pkg::SL_KD:     opb = kd_w;
            ctc_pkg::SL_TC:     opb = tc_w;
            ctc_pkg::SL_SP:     opb = sp_reg;
            ctc_pkg::SL_TH:     opb = th_reg;
            ctc_pkg::SL_SFILT:  opb = sfilt_reg;
            ctc_pkg::SL_DEN:    opb = den_reg;
            ctc_pkg::SL_SPRIN:  opb = sprin_reg;
            ctc_pkg::SL_SPROUT: opb = sprout_reg;
            ctc_pkg::SL_SPAIN:  opb = spain_reg;
            ctc_pkg::SL_SPAOUT: opb = spaout_reg;
            ctc_pkg::SL_ERR:    opb = err_reg;
            ctc_pkg::SL_PERR:   opb = perr_reg;
            ctc_pkg::SL_PERATE: opb = perate_reg;
            ctc_pkg::SL_INTEG:  opb = integ_reg;
            ctc_pkg::SL_ARIN:   opb = arin_reg;
            ctc_pkg::SL_AROUT:  opb = arout_reg;
            ctc_pkg::SL_T0:     opb = t0_reg;
            ctc_pkg::SL_T1:     opb = t1_reg;
            ctc_pkg::SL_T2:     opb = t2_reg;
            default:            opb = '0;
        endcase
    end

    assign arith_start = (state_reg == ST_ISSUE) && (uop.op != ctc_pkg::OP_SIN);
    assign sine_start  = (state_reg == ST_ISSUE) && (uop.op == ctc_pkg::OP_SIN);

    ctc_arith #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (F)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (arith_start),
        .op      (uop.op),
        .opa     (opa),
        .opb     (opb),
        .done    (arith_done),
        .result  (arith_res),
        .ovf     (arith_ovf)
    );

    ctc_sine #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (F)
    ) u_sine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (sine_start),
        .angle_deg (opa),
        .done      (sine_done),
        .sine      (sine_res)
    );

    assign unit_done = arith_done | sine_done;
    assign unit_res  = sine_done ? sine_res : arith_res;
    assign unit_ovf  = arith_done & arith_ovf;

    // fit the finished torque into 32 bits
    assign torque_x  = IW'(t0_reg);
    assign clip      = (torque_x > IW'(32'sh7FFFFFFF)) || (torque_x < IW'(32'sh80000000));
    assign torque_32 = (torque_x > IW'(32'sh7FFFFFFF)) ? 32'h7FFFFFFF :
                       (torque_x < IW'(32'sh80000000)) ? 32'h80000000 :
                       torque_x[31:0];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg    <= 23'd36045;
            length_reg  <= 23'd72090;
            damping_reg <= 23'd36045;
            gravity_reg <= 23'd642908;
            kp_reg      <= 26'd655360;
            ki_reg      <= 26'd393216;
            kd_reg      <= 26'd655360;
            tc_reg      <= 23'd32768;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ctc_pkg::REG_MASS:     mass_reg    <= cfg_wdata[22:0];
                ctc_pkg::REG_LENGTH:   length_reg  <= cfg_wdata[22:0];
                ctc_pkg::REG_DAMPING:  damping_reg <= cfg_wdata[22:0];
                ctc_pkg::REG_GRAVITY:  gravity_reg <= cfg_wdata[22:0];
                ctc_pkg::REG_KP:       kp_reg      <= cfg_wdata;
                ctc_pkg::REG_KI:       ki_reg      <= cfg_wdata;
                ctc_pkg::REG_KD:       kd_reg      <= cfg_wdata;
                ctc_pkg::REG_DERIV_TC: tc_reg      <= cfg_wdata[22:0];
                default: ;
            endcase
        end
    end

    // sequencer, state write-back and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            sfilt_reg   <= '0;
            sprout_reg  <= '0;
            sprin_reg   <= '0;
            spaout_reg  <= '0;
            spain_reg   <= '0;
            arout_reg   <= '0;
            arin_reg    <= '0;
            integ_reg   <= '0;
            perr_reg    <= '0;
            perate_reg  <= '0;
        end else begin
            // free the output register once its item is taken
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        spdeg_reg <= in_word(s_setpoint_deg);
                        thdeg_reg <= in_word(s_measured_deg);
                        step_reg  <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (step_reg == ctc_pkg::STEP_TORQUE) begin
                        hit_reg <= 1'b0;
                    end
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (unit_done) begin
                        if (unit_ovf) begin
                            hit_reg <= 1'b1;
                        end
                        case (uop.dst)
                            ctc_pkg::SL_SP:     sp_reg     <= unit_res;
                            ctc_pkg::SL_TH:     th_reg     <= unit_res;
                            ctc_pkg::SL_SFILT:  sfilt_reg  <= unit_res;
                            ctc_pkg::SL_DEN:    den_reg    <= unit_res;
                            ctc_pkg::SL_SPRIN:  sprin_reg  <= unit_res;
                            ctc_pkg::SL_SPROUT: sprout_reg <= unit_res;
                            ctc_pkg::SL_SPAIN:  spain_reg  <= unit_res;
                            ctc_pkg::SL_SPAOUT: spaout_reg <= unit_res;
                            ctc_pkg::SL_ERR:    err_reg    <= unit_res;
                            ctc_pkg::SL_PERR:   perr_reg   <= unit_res;
                            ctc_pkg::SL_PERATE: perate_reg <= unit_res;
                            ctc_pkg::SL_INTEG:  integ_reg  <= unit_res;
                            ctc_pkg::SL_ARIN:   arin_reg   <= unit_res;
                            ctc_pkg::SL_AROUT:  arout_reg  <= unit_res;
                            ctc_pkg::SL_T0:     t0_reg     <= unit_res;
                            ctc_pkg::SL_T1:     t1_reg     <= unit_res;
                            ctc_pkg::SL_T2:     t2_reg     <= unit_res;
                            default: ;
                        endcase
                        if (step_reg == ctc_pkg::STEP_LAST) begin
                            state_reg <= ST_DONE;
                        end else begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_torque_reg <= torque_32;
                        m_sat_reg    <= hit_reg | clip;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_torque_cmd = m_torque_reg;
    assign m_saturated  = m_sat_reg;

endmodule

>>> hw/rtl/ctc_arith.sv
`timescale 1ns / 1ps

module ctc_arith #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  ctc_pkg::op_t                 op,
    input  logic signed [WORD_WIDTH-1:0] opa,
    input  logic signed [WORD_WIDTH-1:0] opb,
    output logic                         done,
    output logic signed [WORD_WIDTH-1:0] result,
    output logic                         ovf
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int LW = W + F;
    localparam int MW = 2 * W + 1;
    localparam int CW = $clog2(LW + 1);
    localparam logic [W-1:0] WMAX_U = {1'b0, {(W-1){1'b1}}};

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_FIN  = 4'b1000
    } astate_t;

    astate_t             state_reg;
    ctc_pkg::op_t        op_reg;
    logic signed [W-1:0] a_reg, b_reg;
    logic                neg_reg;
    logic [W-1:0]        hi_reg;
    logic [LW-1:0]       lo_reg;
    logic [W-1:0]        d_reg;
    logic [CW-1:0]       cnt_reg;
    logic signed [W-1:0] res_reg;
    logic                ovf_reg;
    logic                done_reg;

    logic [W-1:0]  mag_a, mag_b;
    logic [W:0]    mul_sum;
    logic [W:0]    rem_s, rem_d;
    logic          rem_ge;
    logic [W:0]    add_s;
    logic [MW-1:0] mag, limit, mag_sat;
    logic          over;
    logic signed [W-1:0] fin_res;
    logic          fin_ovf;

    assign mag_a = opa[W-1] ? W'(~opa + 1'b1) : opa;
    assign mag_b = opb[W-1] ? W'(~opb + 1'b1) : opb;

    // one multiply or divide step
    assign mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, d_reg} : '0);
    assign rem_s   = {hi_reg, lo_reg[LW-1]};
    assign rem_d   = rem_s - {1'b0, d_reg};
    assign rem_ge  = rem_s >= {1'b0, d_reg};

    // round, saturate and sign the finished operation
    always_comb begin
        add_s   = '0;
        mag     = '0;
        fin_res = '0;
        fin_ovf = 1'b0;
        limit   = MW'(WMAX_U) + MW'(neg_reg);
        case (op_reg)
            ctc_pkg::OP_ADD, ctc_pkg::OP_SUB: begin
                if (op_reg == ctc_pkg::OP_ADD) begin
                    add_s = {a_reg[W-1], a_reg} + {b_reg[W-1], b_reg};
                end else begin
                    add_s = {a_reg[W-1], a_reg} - {b_reg[W-1], b_reg};
                end
                if (add_s[W] != add_s[W-1]) begin
                    fin_ovf = 1'b1;
                    fin_res = add_s[W] ? {1'b1, {(W-1){1'b0}}} : WMAX_U;
                end else begin
                    fin_res = add_s[W-1:0];
                end
            end
            ctc_pkg::OP_MUL: begin
                mag = (MW'({hi_reg, lo_reg[W-1:0]}) + (MW'(1) << (F - 1))) >> F;
            end
            default: begin
                mag = MW'(lo_reg) + MW'(hi_reg >= (d_reg - hi_reg));
            end
        endcase
        over    = mag > limit;
        mag_sat = over ? limit : mag;
        if (op_reg == ctc_pkg::OP_MUL || op_reg == ctc_pkg::OP_DIV) begin
            fin_ovf = over;
            fin_res = neg_reg ? W'(MW'(0) - mag_sat) : W'(mag_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE: begin
                    if (start) begin
                        op_reg  <= op;
                        a_reg   <= opa;
                        b_reg   <= opb;
                        hi_reg  <= '0;
                        cnt_reg <= '0;
                        case (op)
                            ctc_pkg::OP_MUL: begin
                                neg_reg   <= opa[W-1] ^ opb[W-1];
                                lo_reg    <= LW'(mag_a);
                                d_reg     <= mag_b;
                                state_reg <= A_MUL;
                            end
                            ctc_pkg::OP_DIV: begin
                                neg_reg   <= opa[W-1];
                                lo_reg    <= LW'(mag_a) << F;
                                d_reg     <= opb;
                                state_reg <= A_DIV;
                            end
                            default: begin
                                neg_reg   <= 1'b0;
                                state_reg <= A_FIN;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    hi_reg  <= mul_sum[W:1];
                    lo_reg  <= {lo_reg[LW-1:W], mul_sum[0], lo_reg[W-1:1]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(W - 1)) begin
                        state_reg <= A_FIN;
                    end
                end
                A_DIV: begin
                    hi_reg  <= rem_ge ? rem_d[W-1:0] : rem_s[W-1:0];
                    lo_reg  <= {lo_reg[LW-2:0], rem_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(LW - 1)) begin
                        state_reg <= A_FIN;
                    end
                end
                A_FIN: begin
                    res_reg   <= fin_res;
                    ovf_reg   <= fin_ovf;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
    assign ovf    = ovf_reg;

endmodule

>>> hw/rtl/ctc_sine.sv
`timescale 1ns / 1ps

module ctc_sine #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [WORD_WIDTH-1:0] angle_deg,
    output logic                         done,
    output logic signed [WORD_WIDTH-1:0] sine
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int RW = W + 10;
    localparam int NQ = (W - F > 8) ? W - F - 8 : 1;
    localparam int KW = (NQ > 1) ? $clog2(NQ) : 1;
    localparam int XW = ctc_pkg::CORDIC_XW;
    localparam int ZW = ctc_pkg::CORDIC_ZW;
    localparam int IW = ctc_pkg::CORDIC_IW;
    localparam logic [RW-1:0] PERIOD = RW'(360) << F;
    localparam logic signed [ZW-1:0] Q90 = ZW'(64'sd90 <<< ctc_pkg::CORDIC_Q);
    localparam logic signed [XW-1:0] Y_HALF = XW'(64'sd1 <<< (29 - F));

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_FOLD = 5'b00100,
        S_ROT  = 5'b01000,
        S_OUT  = 5'b10000
    } sstate_t;

    sstate_t              state_reg;
    logic                 neg_reg;
    logic [RW-1:0]        rem_reg;
    logic [KW-1:0]        k_reg;
    logic [IW-1:0]        it_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [W-1:0]  sine_reg;
    logic                 done_reg;

    logic [W-1:0]         mag_in;
    logic [RW-1:0]        per_sh;
    logic [RW-1:0]        r_pos;
    logic signed [ZW-1:0] z0, z1, zf;
    logic signed [XW-1:0] x_sh, y_sh, y_rnd;

    assign mag_in = angle_deg[W-1] ? W'(~angle_deg + 1'b1) : angle_deg;

    // full turn scaled by the current power of two for compare and subtract
    assign per_sh = PERIOD << k_reg;

    // fold the reduced angle into [-90, 90]
    always_comb begin
        r_pos = (neg_reg && rem_reg != '0) ? PERIOD - rem_reg : rem_reg;
        z0    = $signed(ZW'(r_pos)) <<< (ctc_pkg::CORDIC_Q - F);
        z1    = (z0 > 2 * Q90) ? z0 - 4 * Q90 : z0;
        if (z1 > Q90) begin
            zf = 2 * Q90 - z1;
        end else if (z1 < -Q90) begin
            zf = -2 * Q90 - z1;
        end else begin
            zf = z1;
        end
    end

    assign x_sh  = x_reg >>> it_reg;
    assign y_sh  = y_reg >>> it_reg;
    assign y_rnd = (y_reg + Y_HALF) >>> (30 - F);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        neg_reg   <= angle_deg[W-1];
                        rem_reg   <= RW'(mag_in);
                        k_reg     <= KW'(NQ - 1);
                        state_reg <= S_MOD;
                    end
                end
                S_MOD: begin
                    // strip multiples of a full turn, largest first
                    if (rem_reg >= per_sh) begin
                        rem_reg <= rem_reg - per_sh;
                    end
                    k_reg <= k_reg - 1'b1;
                    if (k_reg == '0) begin
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    x_reg     <= ctc_pkg::CORDIC_GAIN;
                    y_reg     <= '0;
                    z_reg     <= zf;
                    it_reg    <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT: begin
                    // rotate toward zero residual angle
                    if (z_reg >= 0) begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - ctc_pkg::ATAN_DEG_Q24[it_reg];
                    end else begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + ctc_pkg::ATAN_DEG_Q24[it_reg];
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IW'(ctc_pkg::CORDIC_STEPS - 1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    sine_reg  <= W'(y_rnd);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign sine = sine_reg;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int       NUM_REGS    = 8;
    localparam longint   WORD_MAX    = 64'sd2147483647;
    localparam longint   WORD_MIN    = -64'sd2147483648;
    localparam longint   TICK_STEP   = 655;
    localparam longint   LOWPASS_TC  = 196608;
    localparam longint   DEG_TO_RAD  = 1144;
    localparam longint   SIN_GAIN    = 652032874;
    localparam longint   Q90         = 64'sd90 <<< 24;
    localparam int       HOLD_CYCLES = 8000;
    localparam longint   CYCLE_LIMIT = 20000000;

    typedef struct {
        logic signed [31:0] torque;
        logic               sat;
    } torque_item_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [ctc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic signed [31:0]              s_setpoint_deg;
    logic signed [31:0]              s_measured_deg;
    logic                            m_valid;
    logic                            m_ready;
    logic signed [31:0]              m_torque_cmd;
    logic                            m_saturated;

    computed_torque_controller dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_setpoint_deg (s_setpoint_deg),
        .s_measured_deg (s_measured_deg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_torque_cmd   (m_torque_cmd),
        .m_saturated    (m_saturated)
    );

    // Controller model state
    longint       gain_reg [NUM_REGS];
    longint       sp_filt, sp_rate_y, sp_rate_u, sp_acc_y, sp_acc_u;
    longint       th_rate_y, th_rate_u, integ, err_last, err_rate_prev;
    bit           clip_seen;
    torque_item_t torque_queue [$];

    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_request;
    int     hold_left;
    int     mismatches;
    longint cycle_count;

    function automatic int reg_width(input int idx);
        return (idx >= 4 && idx <= 6) ? 26 : 23;
    endfunction

    function automatic longint fit_word(input bit neg, input longint mag);
        longint lim;
        lim = neg ? WORD_MAX + 1 : WORD_MAX;
        if (mag > lim) begin
            clip_seen = 1'b1;
            mag = lim;
        end
        return neg ? -mag : mag;
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > WORD_MAX) begin
            clip_seen = 1'b1;
            return WORD_MAX;
        end
        if (s < WORD_MIN) begin
            clip_seen = 1'b1;
            return WORD_MIN;
        end
        return s;
    endfunction

    function automatic longint sub_sat(input longint a, input longint b);
        return add_sat(a, -b);
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        longint ma, mb, q;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        q = (ma * mb + 32768) >> 16;
        return fit_word((a < 0) != (b < 0), q);
    endfunction

    // Round to nearest, ties away from zero; den is always positive
    function automatic longint div_q(input longint num, input longint den);
        longint n, q, r;
        n = (num < 0 ? -num : num) <<< 16;
        q = n / den;
        r = n % den;
        if (r >= den - r)
            q++;
        return fit_word(num < 0, q);
    endfunction

    function automatic longint filt_rate(input longint u, input longint tc, input longint den,
                                         inout longint y_prev, inout longint u_prev);
        longint y;
        y = div_q(add_sat(sub_sat(u, u_prev), mul_q(tc, y_prev)), den);
        y_prev = y;
        u_prev = u;
        return y;
    endfunction

    function automatic longint atan_q24(input int i);
        return ctc_pkg::ATAN_DEG_Q24[i];
    endfunction

    // Sine of a degree angle: reduce, fold into [-90,90], rotate
    function automatic longint sin_deg_q(input longint deg);
        longint period, r, x, y, z, nx;
        period = 64'sd360 <<< 16;
        r = deg % period;
        if (r < 0)
            r += period;
        z = r <<< 8;
        if (z > 2 * Q90)
            z -= 4 * Q90;
        if (z > Q90)
            z = 2 * Q90 - z;
        else if (z < -Q90)
            z = -2 * Q90 - z;
        x = SIN_GAIN;
        y = 0;
        for (int i = 0; i < ctc_pkg::CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_q24(i);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_q24(i);
            end
            x = nx;
        end
        return (y + (64'sd1 <<< 13)) >>> 14;
    endfunction

    function automatic torque_item_t predict_torque(input logic signed [31:0] sp_deg,
                                                    input logic signed [31:0] th_deg);
        longint sp, th, tc, den, d1, d2, err, derr, pid, dth, inertia, grav, tq;
        torque_item_t res;
        sp = mul_q(longint'(sp_deg), DEG_TO_RAD);
        th = mul_q(longint'(th_deg), DEG_TO_RAD);
        sp_filt = div_q(add_sat(mul_q(TICK_STEP, sp), mul_q(LOWPASS_TC, sp_filt)),
                        TICK_STEP + LOWPASS_TC);
        tc = gain_reg[ctc_pkg::REG_DERIV_TC];
        den = add_sat(TICK_STEP, tc);
        d1 = filt_rate(sp_filt, tc, den, sp_rate_y, sp_rate_u);
        d2 = filt_rate(d1, tc, den, sp_acc_y, sp_acc_u);
        err = sub_sat(sp_filt, th);
        integ = add_sat(integ, mul_q(mul_q(gain_reg[ctc_pkg::REG_KI], err), TICK_STEP));
        derr = div_q(add_sat(sub_sat(err, err_last), mul_q(tc, err_rate_prev)), den);
        err_last = err;
        err_rate_prev = derr;
        pid = add_sat(add_sat(mul_q(gain_reg[ctc_pkg::REG_KP], err), integ),
                      mul_q(gain_reg[ctc_pkg::REG_KD], derr));
        dth = filt_rate(th, tc, den, th_rate_y, th_rate_u);
        // only the torque formula itself raises the flag
        clip_seen = 1'b0;
        inertia = mul_q(mul_q(gain_reg[ctc_pkg::REG_MASS], gain_reg[ctc_pkg::REG_LENGTH]),
                        gain_reg[ctc_pkg::REG_LENGTH]);
        grav = mul_q(mul_q(mul_q(sin_deg_q(longint'(th_deg)), gain_reg[ctc_pkg::REG_MASS]),
                           gain_reg[ctc_pkg::REG_LENGTH]), gain_reg[ctc_pkg::REG_GRAVITY]);
        tq = add_sat(add_sat(mul_q(add_sat(d2, pid), inertia), grav),
                     mul_q(dth, gain_reg[ctc_pkg::REG_DAMPING]));
        res.torque = tq[31:0];
        res.sat = clip_seen;
        return res;
    endfunction

    // Clock and cycle limit
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expected one
    always @(posedge aclk) begin
        torque_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (torque_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: torque=%0d sat=%0b",
                             m_torque_cmd, m_saturated);
            end else begin
                want = torque_queue.pop_front();
                if (m_torque_cmd !== want.torque || m_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: torque exp=%0d got=%0d, sat exp=%0b got=%0b",
                                 want.torque, m_torque_cmd, want.sat, m_saturated);
                end
            end
        end
    end

    // Offer one tick, hold it until accepted, then update the model
    task automatic send_tick(input logic signed [31:0] sp, input logic signed [31:0] th);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_setpoint_deg <= sp;
        s_measured_deg <= th;
        do
            @(posedge aclk);
        while (!s_ready);
        torque_queue.push_back(predict_torque(sp, th));
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (torque_queue.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // Write all registers while idle; stray data bits and a bad index included
    task automatic load_gains(input logic [ctc_pkg::CFG_DATA_W-1:0] vals [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ctc_pkg::CFG_INDEX_W'(i);
            cfg_wdata <= vals[i];
            gain_reg[i] = longint'(vals[i] & ((26'd1 << reg_width(i)) - 1));
            @(posedge aclk);
        end
        cfg_index <= ctc_pkg::CFG_INDEX_W'($urandom_range(15, NUM_REGS));
        cfg_wdata <= ctc_pkg::CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_angle;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $signed(32'($urandom_range(0, 1440 << 16))) - (720 << 16);
        if (pick < 85)
            return $signed(32'($urandom_range(0, 8 << 16))) - (4 << 16);
        return $signed(32'($urandom));
    endfunction

    function automatic logic [ctc_pkg::CFG_DATA_W-1:0] rand_gain(input int idx);
        if ($urandom_range(3) == 0)
            return ctc_pkg::CFG_DATA_W'($urandom);
        return (idx >= 4 && idx <= 6) ? ctc_pkg::CFG_DATA_W'($urandom_range(0, 65536000))
                                      : ctc_pkg::CFG_DATA_W'($urandom_range(0, 6553600));
    endfunction

    task automatic test_directed_extremes;
        logic signed [31:0] angles [16];
        angles = '{32'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1, -32'sd1,
                   32'sd90 <<< 16, -(32'sd90 <<< 16), 32'sd180 <<< 16,
                   32'sd270 <<< 16, 32'sd360 <<< 16, 32'sd450 <<< 16,
                   -(32'sd360 <<< 16), 32'sd45 <<< 16, -(32'sd135 <<< 16),
                   32'sh55555555, 32'shAAAAAAAA};
        for (int i = 0; i < 16; i++)
            send_tick(angles[i], angles[15 - i]);
        send_tick(32'sh7FFFFFFF, 32'sh80000000);
        send_tick(32'sh80000000, 32'sh7FFFFFFF);
        send_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        drain();
    endtask

    task automatic test_gain_extremes;
        logic [ctc_pkg::CFG_DATA_W-1:0] vals [NUM_REGS];
        // all zero: zero filter constant, no plant terms
        vals = '{default: '0};
        load_gains(vals);
        for (int i = 0; i < 6; i++)
            send_tick(rand_angle(), rand_angle());
        drain();
        // every register at its full width, with stray upper bits set
        vals = '{default: '1};
        load_gains(vals);
        for (int i = 0; i < 6; i++)
            send_tick(rand_angle(), rand_angle());
        drain();
    endtask

    task automatic test_random_ticks(input int count, input int s_idle, input int r_idle);
        logic [ctc_pkg::CFG_DATA_W-1:0] vals [NUM_REGS];
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < NUM_REGS; i++)
            vals[i] = rand_gain(i);
        load_gains(vals);
        for (int i = 0; i < count; i++)
            send_tick(rand_angle(), rand_angle());
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++)
            send_tick(rand_angle(), rand_angle());
        drain();
    endtask

    initial begin
        logic [ctc_pkg::CFG_DATA_W-1:0] defaults [NUM_REGS];
        defaults = '{36045, 72090, 36045, 642908, 655360, 393216, 655360, 32768};
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_setpoint_deg <= '0;
        s_measured_deg <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b0;
        hold_left = 0;
        mismatches = 0;
        cycle_count = 0;
        for (int i = 0; i < NUM_REGS; i++)
            gain_reg[i] = longint'(defaults[i]);
        {sp_filt, sp_rate_y, sp_rate_u, sp_acc_y, sp_acc_u} = '0;
        {th_rate_y, th_rate_u, integ, err_last, err_rate_prev} = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_gain_extremes();
        load_gains(defaults);
        test_random_ticks(300, 8, 71);
        test_random_ticks(300, 8, 71);
        test_random_ticks(300, 71, 8);
        test_random_ticks(300, 71, 8);
        test_backpressure();
        test_random_ticks(300, 0, 0);
        test_random_ticks(300, 0, 0);

        repeat (200) @(posedge aclk);
        if (mismatches == 0 && torque_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
